/* design/rpc_pkg.sv */
package rpc_pkg;

	// back-end sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VMUL,
		ST_VSUB,
		ST_WALK,
		ST_MSQ,
		ST_MPRD,
		ST_CHECK,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} bk_state_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PAIR = 1'b1;

	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	localparam int FRAC_BITS  = 30;
	localparam int DIV_STEPS  = 2 * FRAC_BITS;
	localparam int SQRT_STEPS = FRAC_BITS;

	// queue status seen by the front end
	typedef struct packed {
		logic full;
		logic pending;
	} q_status_t;

endpackage

/* design/rpc_front.sv */
module rpc_front import rpc_pkg::*; #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLS    = 256,
	parameter int SAMPLE_BITS = 16,
	localparam int RAW  = $clog2(MAX_ROWS),
	localparam int CB   = $clog2(MAX_COLS),
	localparam int NB   = CB + 1,
	localparam int RCW  = RAW + 1,
	localparam int SUMW = SAMPLE_BITS + CB + 1,
	localparam int SQW  = 2 * SAMPLE_BITS - 1 + CB,
	localparam int EW   = 9 + 2 * SUMW + 2 * SQW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [3:0]                    row_a,
	input  logic [3:0]                    row_b,
	input  logic [7:0]                    column,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [RCW-1:0]                rows_eff,
	input  logic [NB-1:0]                 cols_eff,
	input  q_status_t                     q_stat,
	output logic                          push,
	output logic [EW-1:0]                 push_data,
	output logic                          wr_en,
	output logic [RAW+CB-1:0]             wr_addr,
	output logic signed [SAMPLE_BITS-1:0] wr_data
);

	localparam int DEPTH = 1 << RAW;
	localparam int CW    = 16;

	logic                          valid_s1;
	logic                          cmd_s1;
	logic [3:0]                    ra_s1, rb_s1;
	logic [7:0]                    col_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic [SUMW-1:0]               sum_a_s1, sum_b_s1;
	logic [SQW-1:0]                sq_a_s1, sq_b_s1;

	logic [SUMW-1:0] sum_mem [DEPTH];
	logic [SQW-1:0]  sq_mem  [DEPTH];
	logic [DEPTH-1:0] seen_q;

	logic accept, s1_fire, ld_ok, a_ok, b_ok, upd;
	logic [RAW-1:0] idx_a, idx_b, idx_s1;
	logic signed [2*SAMPLE_BITS-1:0] sq_full;
	logic [SUMW-1:0] new_sum;
	logic [SQW-1:0]  new_sq;

	assign idx_a  = RAW'(row_a);
	assign idx_b  = RAW'(row_b);
	assign idx_s1 = RAW'(ra_s1);

	assign a_ok  = CW'(ra_s1) < CW'(rows_eff);
	assign b_ok  = CW'(rb_s1) < CW'(rows_eff);
	assign ld_ok = (cmd_s1 == CMD_LOAD) && a_ok && (CW'(col_s1) < CW'(cols_eff));

	// pairs need a queue slot; loads wait until no pair is outstanding
	assign s1_fire  = valid_s1 && ((cmd_s1 == CMD_PAIR) ? !q_stat.full : !q_stat.pending);
	assign in_stall = valid_s1 && !s1_fire;
	assign accept   = in_valid && !in_stall;
	assign upd      = s1_fire && ld_ok;

	assign sq_full = smp_s1 * smp_s1;
	assign new_sum = (col_s1 == 8'd0) ? SUMW'(smp_s1) : sum_a_s1 + SUMW'(smp_s1);
	assign new_sq  = (col_s1 == 8'd0) ? SQW'($unsigned(sq_full))
	                                  : sq_a_s1 + SQW'($unsigned(sq_full));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			seen_q   <= '0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (s1_fire) valid_s1 <= 1'b0;
			if (upd) seen_q[idx_s1] <= 1'b1;
		end
	end

	// sums: registered read, write-first forwarding from the load in flight
	always_ff @(posedge clk) begin
		if (upd) begin
			sum_mem[idx_s1] <= new_sum;
			sq_mem[idx_s1]  <= new_sq;
		end
		if (accept) begin
			cmd_s1 <= command;
			ra_s1  <= row_a;
			rb_s1  <= row_b;
			col_s1 <= column;
			smp_s1 <= sample;
			sum_a_s1 <= (upd && idx_s1 == idx_a) ? new_sum
			          : (seen_q[idx_a] ? sum_mem[idx_a] : '0);
			sum_b_s1 <= (upd && idx_s1 == idx_b) ? new_sum
			          : (seen_q[idx_b] ? sum_mem[idx_b] : '0);
			sq_a_s1  <= (upd && idx_s1 == idx_a) ? new_sq
			          : (seen_q[idx_a] ? sq_mem[idx_a] : '0);
			sq_b_s1  <= (upd && idx_s1 == idx_b) ? new_sq
			          : (seen_q[idx_b] ? sq_mem[idx_b] : '0);
		end
	end

	assign push      = s1_fire && (cmd_s1 == CMD_PAIR);
	assign push_data = {ra_s1, rb_s1, !(a_ok && b_ok), sum_a_s1, sum_b_s1, sq_a_s1, sq_b_s1};

	assign wr_en   = upd;
	assign wr_addr = {idx_s1, CB'(col_s1)};
	assign wr_data = smp_s1;

endmodule

/* design/rpc_queue.sv */
module rpc_queue import rpc_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	input  logic             busy,
	output logic             head_valid,
	output logic [WIDTH-1:0] head,
	output q_status_t        q_stat
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= push_data;
	end

	assign head           = slot_q[rp_q];
	assign head_valid     = cnt_q != 2'd0;
	assign q_stat.full    = cnt_q == 2'd2;
	assign q_stat.pending = (cnt_q != 2'd0) || busy;

endmodule

/* design/rpc_back.sv */
module rpc_back import rpc_pkg::*; #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLS    = 256,
	parameter int SAMPLE_BITS = 16,
	localparam int RAW  = $clog2(MAX_ROWS),
	localparam int CB   = $clog2(MAX_COLS),
	localparam int NB   = CB + 1,
	localparam int SUMW = SAMPLE_BITS + CB + 1,
	localparam int SQW  = 2 * SAMPLE_BITS - 1 + CB,
	localparam int EW   = 9 + 2 * SUMW + 2 * SQW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [NB-1:0]                 cols_eff,
	input  logic                          head_valid,
	input  logic [EW-1:0]                 head,
	output logic                          pop,
	output logic                          busy,
	input  logic                          wr_en,
	input  logic [RAW+CB-1:0]             wr_addr,
	input  logic signed [SAMPLE_BITS-1:0] wr_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [3:0]                    first_row,
	output logic [3:0]                    second_row,
	output logic signed [31:0]            correlation,
	output logic                          degenerate
);

	localparam int SB   = SAMPLE_BITS;
	localparam int DW   = 2 * SB + CB;
	localparam int XW   = DW;
	localparam int VW   = 2 * SB + 2 * CB + 2;
	localparam int VU   = VW - 1;
	localparam int PW   = 2 * VU;
	localparam int RW   = PW + 1;
	localparam int CNTW = 8;
	localparam int QW   = 2 * FRAC_BITS;

	localparam logic [1:0] PH_VAR_A = 2'd0;
	localparam logic [1:0] PH_VAR_B = 2'd1;
	localparam logic [1:0] PH_NUM   = 2'd2;

	bk_state_t state_q, state_d;

	logic [3:0]      h_ra, h_rb;
	logic            h_oob;
	logic [SUMW-1:0] h_si, h_sj;
	logic [SQW-1:0]  h_qi, h_qj;

	logic [1:0]      phase_q;
	logic [3:0]      ra_q, rb_q;
	logic [SUMW-1:0] si_q, sj_q;
	logic [SQW-1:0]  qi_q, qj_q;

	logic signed [XW-1:0]   x_op;
	logic signed [SUMW-1:0] y_op, z_op;
	logic signed [VW-1:0]   pm_q, ps_q, vi_q, vj_q, diff;
	logic [VW-1:0]          mag_full;

	logic signed [SB-1:0] store [(1 << RAW) * (1 << CB)];
	logic [NB-1:0]        col_q;
	logic                 issue, walk_done, rd_v_s1, mul_v_s2;
	logic signed [SB-1:0] da_s1, db_s1;
	logic signed [2*SB-1:0] prod_s2;
	logic signed [DW-1:0] dot_q;

	logic [VU-1:0]   mul_a_q;
	logic [PW-1:0]   p_q, m2_q, p_next;
	logic [VU:0]     psum;
	logic [CNTW-1:0] cnt_q;

	logic            neg_q, deg_q, sat_q;
	logic [RW-1:0]   rem_q, rem_sh;
	logic            rem_ge;
	logic [QW-1:0]   quo_q, quo_next, sx_q;
	logic [FRAC_BITS-1:0] root_q;
	logic [FRAC_BITS+3:0] srem_q, srem_sh, trial;
	logic            srem_ge;
	logic [FRAC_BITS:0]   qval;

	logic            out_valid_q, deg_out_q;
	logic [3:0]      fr_q, sr_q;
	logic signed [31:0] corr_q;
	logic            out_free;

	assign {h_ra, h_rb, h_oob, h_si, h_sj, h_qi, h_qj} = head;

	assign pop  = (state_q == ST_IDLE) && head_valid;
	assign busy = state_q != ST_IDLE;

	// shared product pair: n*X and Y*Z
	always_comb begin
		case (phase_q)
			PH_VAR_A: begin
				x_op = signed'({1'b0, qi_q});
				y_op = signed'(si_q);
				z_op = signed'(si_q);
			end
			PH_VAR_B: begin
				x_op = signed'({1'b0, qj_q});
				y_op = signed'(sj_q);
				z_op = signed'(sj_q);
			end
			default: begin
				x_op = dot_q;
				y_op = signed'(si_q);
				z_op = signed'(sj_q);
			end
		endcase
	end

	assign diff     = pm_q - ps_q;
	assign mag_full = diff[VW-1] ? VW'(-diff) : VW'(diff);

	// column walk
	assign issue     = (state_q == ST_WALK) && (col_q < cols_eff);
	assign walk_done = (state_q == ST_WALK) && !issue && !rd_v_s1 && !mul_v_s2;

	// shift-add multiplier step
	assign psum   = {1'b0, p_q[PW-1:VU]} + (p_q[0] ? {1'b0, mul_a_q} : '0);
	assign p_next = {psum, p_q[VU-1:1]};

	// restoring division step
	assign rem_sh   = {rem_q[RW-2:0], 1'b0};
	assign rem_ge   = rem_sh >= RW'(p_q);
	assign quo_next = {quo_q[QW-2:0], rem_ge};

	// digit-by-digit square root step
	assign srem_sh = {srem_q[FRAC_BITS+1:0], sx_q[QW-1:QW-2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign srem_ge = srem_sh >= trial;

	assign qval     = sat_q ? (FRAC_BITS+1)'(1) << FRAC_BITS : {1'b0, root_q};
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (head_valid) state_d = h_oob ? ST_DONE : ST_VMUL;
			ST_VMUL:  state_d = ST_VSUB;
			ST_VSUB: begin
				if (phase_q == PH_VAR_A) state_d = ST_VMUL;
				else if (phase_q == PH_VAR_B)
					state_d = (vi_q <= 0 || diff <= 0) ? ST_DONE : ST_WALK;
				else state_d = ST_MSQ;
			end
			ST_WALK:  if (walk_done) state_d = ST_VMUL;
			ST_MSQ:   if (cnt_q == CNTW'(VU - 1)) state_d = ST_MPRD;
			ST_MPRD:  if (cnt_q == CNTW'(VU - 1)) state_d = ST_CHECK;
			ST_CHECK: state_d = (m2_q >= p_q) ? ST_DONE : ST_DIV;
			ST_DIV:   if (cnt_q == CNTW'(DIV_STEPS - 1)) state_d = ST_SQRT;
			ST_SQRT:  if (cnt_q == CNTW'(SQRT_STEPS - 1)) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_v_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_v_s1  <= issue;
			mul_v_s2 <= rd_v_s1;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// sample store: one write port from the front end, two read ports for the walk
	always_ff @(posedge clk) begin
		if (wr_en) store[wr_addr] <= wr_data;
		if (issue) begin
			da_s1 <= store[{RAW'(ra_q), col_q[CB-1:0]}];
			db_s1 <= store[{RAW'(rb_q), col_q[CB-1:0]}];
		end
		if (rd_v_s1) prod_s2 <= da_s1 * db_s1;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ra_q    <= h_ra;
				rb_q    <= h_rb;
				si_q    <= h_si;
				sj_q    <= h_sj;
				qi_q    <= h_qi;
				qj_q    <= h_qj;
				deg_q   <= h_oob;
				sat_q   <= 1'b0;
				phase_q <= PH_VAR_A;
			end
			ST_VMUL: begin
				pm_q <= signed'({1'b0, cols_eff}) * x_op;
				ps_q <= y_op * z_op;
			end
			ST_VSUB: begin
				cnt_q <= '0;
				if (phase_q == PH_VAR_A) begin
					vi_q    <= diff;
					phase_q <= PH_VAR_B;
				end else if (phase_q == PH_VAR_B) begin
					vj_q    <= diff;
					phase_q <= PH_NUM;
					col_q   <= '0;
					dot_q   <= '0;
					if (vi_q <= 0 || diff <= 0) deg_q <= 1'b1;
				end else begin
					neg_q   <= diff[VW-1];
					mul_a_q <= VU'(mag_full);
					p_q     <= {{VU{1'b0}}, VU'(mag_full)};
				end
			end
			ST_WALK: begin
				if (issue) col_q <= col_q + NB'(1);
				if (mul_v_s2) dot_q <= dot_q + DW'(prod_s2);
			end
			ST_MSQ: begin
				cnt_q <= cnt_q + CNTW'(1);
				p_q   <= p_next;
				if (cnt_q == CNTW'(VU - 1)) begin
					m2_q    <= p_next;
					mul_a_q <= vi_q[VU-1:0];
					p_q     <= {{VU{1'b0}}, vj_q[VU-1:0]};
					cnt_q   <= '0;
				end
			end
			ST_MPRD: begin
				cnt_q <= cnt_q + CNTW'(1);
				p_q   <= p_next;
			end
			ST_CHECK: begin
				cnt_q <= '0;
				rem_q <= RW'(m2_q);
				quo_q <= '0;
				if (m2_q >= p_q) sat_q <= 1'b1;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + CNTW'(1);
				rem_q <= rem_ge ? rem_sh - RW'(p_q) : rem_sh;
				quo_q <= quo_next;
				if (cnt_q == CNTW'(DIV_STEPS - 1)) begin
					sx_q   <= quo_next;
					root_q <= '0;
					srem_q <= '0;
					cnt_q  <= '0;
				end
			end
			ST_SQRT: begin
				cnt_q  <= cnt_q + CNTW'(1);
				srem_q <= srem_ge ? srem_sh - trial : srem_sh;
				root_q <= {root_q[FRAC_BITS-2:0], srem_ge};
				sx_q   <= {sx_q[QW-3:0], 2'b00};
			end
			ST_DONE: begin
				if (out_free) begin
					fr_q      <= ra_q;
					sr_q      <= rb_q;
					deg_out_q <= deg_q;
					if (deg_q) corr_q <= '0;
					else if (neg_q) corr_q <= -signed'(32'(qval));
					else corr_q <= signed'(32'(qval));
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign first_row   = fr_q;
	assign second_row  = sr_q;
	assign correlation = corr_q;
	assign degenerate  = deg_out_q;

endmodule

/* design/row_pair_correlation.sv */
// Channel  Direction  Handshake           Word
// in       sink       in_valid/in_stall   command, row_a, row_b, column, sample
// out      source     out_valid/out_stall first_row, second_row, correlation, degenerate
// cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data (row_count, col_count)
//
// Loads run at one word per clock unless in_stall holds them. A pair goes through
// the column walk over the sample RAM, a shift-add squaring and a shift-add product,
// a 60-step divider and a 30-step root.
// A load waits while any pair is queued or in the back end; pairs queue two deep.
// Reset clears the row sums and the control state at once; the sample RAM is not cleared.
// out_stall only holds the output register; the back end waits on it in its last state.
module row_pair_correlation import rpc_pkg::*; #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLS    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [3:0]                    row_a,
	input  logic [3:0]                    row_b,
	input  logic [7:0]                    column,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [3:0]                    first_row,
	output logic [3:0]                    second_row,
	output logic signed [31:0]            correlation,
	output logic                          degenerate,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [8:0]                    cfg_data
);

	localparam int RAW  = $clog2(MAX_ROWS);
	localparam int CB   = $clog2(MAX_COLS);
	localparam int NB   = CB + 1;
	localparam int RCW  = RAW + 1;
	localparam int SUMW = SAMPLE_BITS + CB + 1;
	localparam int SQW  = 2 * SAMPLE_BITS - 1 + CB;
	localparam int EW   = 9 + 2 * SUMW + 2 * SQW;

	logic [4:0]     row_count_q;
	logic [8:0]     col_count_q;
	logic [RCW-1:0] rows_eff;
	logic [NB-1:0]  cols_eff;

	q_status_t      q_stat;
	logic           push, pop, head_valid, busy;
	logic [EW-1:0]  push_data, head;

	logic                          store_wr_en;
	logic [RAW+CB-1:0]             store_wr_addr;
	logic signed [SAMPLE_BITS-1:0] store_wr_data;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 5'd1;
			col_count_q <= 9'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data[4:0];
				REG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp the programmed sizes to 1..MAX
	always_comb begin
		if (row_count_q == 5'd0) rows_eff = RCW'(1);
		else if (int'(row_count_q) > MAX_ROWS) rows_eff = RCW'(MAX_ROWS);
		else rows_eff = RCW'(row_count_q);

		if (col_count_q == 9'd0) cols_eff = NB'(1);
		else if (int'(col_count_q) > MAX_COLS) cols_eff = NB'(MAX_COLS);
		else cols_eff = NB'(col_count_q);
	end

	// front end: takes words, keeps row sums, forwards samples and pair requests
	rpc_front #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.row_a    (row_a),
		.row_b    (row_b),
		.column   (column),
		.sample   (sample),
		.rows_eff (rows_eff),
		.cols_eff (cols_eff),
		.q_stat   (q_stat),
		.push     (push),
		.push_data(push_data),
		.wr_en    (store_wr_en),
		.wr_addr  (store_wr_addr),
		.wr_data  (store_wr_data)
	);

	// two-deep request queue between the halves
	rpc_queue #(
		.WIDTH(EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.busy      (busy),
		.head_valid(head_valid),
		.head      (head),
		.q_stat    (q_stat)
	);

	// back end: sample RAM, dot product walk, division and root
	rpc_back #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cols_eff   (cols_eff),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.busy       (busy),
		.wr_en      (store_wr_en),
		.wr_addr    (store_wr_addr),
		.wr_data    (store_wr_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.first_row  (first_row),
		.second_row (second_row),
		.correlation(correlation),
		.degenerate (degenerate)
	);

`ifndef NO_ASSERTIONS
	// the RAM must not change under a pair that is still queued or being walked
	a_no_load_under_pair: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr_en |-> !q_stat.pending)
		else $error("sample write while a pair is outstanding");

	// a degenerate word carries zero
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (correlation == 32'sd0))
		else $error("degenerate word with nonzero correlation");

	// result stays within plus and minus one in Q1.30
	a_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((correlation <= 32'sh4000_0000) && (correlation >= -32'sh4000_0000)))
		else $error("correlation outside unit range");

	// the queue never takes a word while full
	a_queue_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue overrun");
`endif

endmodule
